// ===== rtl/pvtg_pkg.sv =====
// ----------------------------------------------------------------------------
// pvtg_pkg
// Widths, status codes and controller/datapath command types of the pooled
// variance block.
// ----------------------------------------------------------------------------
package pvtg_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 16;
  localparam int SUM_W     = 32;
  localparam int SUMSQ_W   = 47;
  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = 48;
  localparam int PROD_W    = 64;
  localparam int MUL_W     = 32;
  localparam int QLO_W     = 24;
  localparam int DIV_W     = PROD_W + FRAC_BITS;
  localparam int DVSR_W    = COUNT_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = 16'hFFFF;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_MUL_SQ,
    DP_DIFF,
    DP_DIV_GROUP,
    DP_ADD_SS,
    DP_DIV_POOL,
    DP_LOAD_EMPTY,
    DP_LOAD_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   grp;
  } dp_cmd_t;

  typedef struct packed {
    logic group_empty;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/pvtg_in_if.sv =====
// ----------------------------------------------------------------------------
// pvtg_in_if
// Sample request channel: one tagged sample per request.
// ----------------------------------------------------------------------------
interface pvtg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pvtg_pkg::SAMPLE_W-1:0] sample;
  logic                                group;
  logic                                missing;
  logic                                last;

  modport source (output valid, output sample, output group, output missing,
                  output last, input ready);
  modport sink (input valid, input sample, input group, input missing,
                input last, output ready);
endinterface

// ===== rtl/pvtg_out_if.sv =====
// ----------------------------------------------------------------------------
// pvtg_out_if
// Result request channel: pooled variance and status of one data set.
// ----------------------------------------------------------------------------
interface pvtg_out_if;
  logic                           valid;
  logic                           ready;
  logic [pvtg_pkg::OUT_W-1:0]     pooled_variance;
  logic [1:0]                     status;

  modport source (output valid, output pooled_variance, output status,
                  input ready);
  modport sink (input valid, input pooled_variance, input status,
                output ready);
endinterface

// ===== rtl/pvtg_divider.sv =====
// ----------------------------------------------------------------------------
// pvtg_divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module pvtg_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pvtg_pkg::DIV_W-1:0]    dividend,
  input  logic [pvtg_pkg::DVSR_W-1:0]   divisor,
  output logic [pvtg_pkg::DIV_W-1:0]    quotient,
  output logic                          done
);

  logic [pvtg_pkg::DIV_W-1:0]     work;
  logic [pvtg_pkg::DVSR_W-1:0]    rem;
  logic [pvtg_pkg::DVSR_W-1:0]    dvsr;
  logic [pvtg_pkg::DIV_CNT_W-1:0] count;
  logic [pvtg_pkg::DVSR_W:0]      rem_sh;
  logic [pvtg_pkg::DVSR_W:0]      rem_sub;
  logic                           fits;

  always_comb begin
    rem_sh  = {rem, work[pvtg_pkg::DIV_W-1]};
    fits    = rem_sh >= {1'b0, dvsr};
    rem_sub = rem_sh - {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= pvtg_pkg::DIV_CNT_W'(pvtg_pkg::DIV_W);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      done  <= (count == pvtg_pkg::DIV_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (count != '0) begin
      work <= {work[pvtg_pkg::DIV_W-2:0], fits};
      rem  <= fits ? rem_sub[pvtg_pkg::DVSR_W-1:0] : rem_sh[pvtg_pkg::DVSR_W-1:0];
    end
  end

  assign quotient = work;

endmodule

// ===== rtl/pvtg_datapath.sv =====
// ----------------------------------------------------------------------------
// pvtg_datapath
// Per-group accumulators, shared multiplier, group and pooled division, and
// the result register.
// ----------------------------------------------------------------------------
module pvtg_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 acc_en,
  input  logic signed [pvtg_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 group,
  input  logic                                 missing,
  input  pvtg_pkg::dp_cmd_t                    cmd,
  output pvtg_pkg::dp_stat_t                   stat,
  output logic [pvtg_pkg::OUT_W-1:0]           pooled_variance,
  output logic [1:0]                           status
);

  logic        [pvtg_pkg::COUNT_W-1:0] count_first, count_second;
  logic signed [pvtg_pkg::SUM_W-1:0]   sum_first, sum_second;
  logic        [pvtg_pkg::SUMSQ_W-1:0] sumsq_first, sumsq_second;
  logic                                overflow_seen;

  logic [2*pvtg_pkg::SAMPLE_W-1:0]     sample_sq;
  logic                                clear;

  logic        [pvtg_pkg::COUNT_W-1:0] n_sel;
  logic signed [pvtg_pkg::SUM_W-1:0]   s_sel;
  logic        [pvtg_pkg::SUMSQ_W-1:0] q_sel;
  logic        [pvtg_pkg::MUL_W-1:0]   s_mag;
  logic        [pvtg_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic        [pvtg_pkg::PROD_W-1:0]  mul_p;
  logic        [pvtg_pkg::DVSR_W-1:0]  total, den;

  logic [pvtg_pkg::PROD_W-1:0] prod, nq, diff, ss_acc;

  logic                          div_start;
  logic [pvtg_pkg::DIV_W-1:0]    div_dividend, div_quotient;
  logic [pvtg_pkg::DVSR_W-1:0]   div_divisor;
  logic                          div_done;

  assign clear     = (cmd.op == pvtg_pkg::DP_LOAD_EMPTY) || (cmd.op == pvtg_pkg::DP_LOAD_RESULT);
  assign sample_sq = unsigned'((2*pvtg_pkg::SAMPLE_W)'(sample) *
                               (2*pvtg_pkg::SAMPLE_W)'(sample));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count_first   <= '0;
      count_second  <= '0;
      sum_first     <= '0;
      sum_second    <= '0;
      sumsq_first   <= '0;
      sumsq_second  <= '0;
      overflow_seen <= 1'b0;
    end else if (acc_en && !missing) begin
      if (!group) begin
        if (count_first == pvtg_pkg::MAX_SAMPLES) begin
          overflow_seen <= 1'b1;
        end else begin
          count_first <= count_first + 1'b1;
          sum_first   <= sum_first + pvtg_pkg::SUM_W'(sample);
          sumsq_first <= sumsq_first + pvtg_pkg::SUMSQ_W'(sample_sq);
        end
      end else begin
        if (count_second == pvtg_pkg::MAX_SAMPLES) begin
          overflow_seen <= 1'b1;
        end else begin
          count_second <= count_second + 1'b1;
          sum_second   <= sum_second + pvtg_pkg::SUM_W'(sample);
          sumsq_second <= sumsq_second + pvtg_pkg::SUMSQ_W'(sample_sq);
        end
      end
    end
  end

  always_comb begin
    n_sel = cmd.grp ? count_second : count_first;
    s_sel = cmd.grp ? sum_second   : sum_first;
    q_sel = cmd.grp ? sumsq_second : sumsq_first;
    s_mag = s_sel[pvtg_pkg::SUM_W-1] ? pvtg_pkg::MUL_W'(-s_sel) : pvtg_pkg::MUL_W'(s_sel);
    total = {1'b0, count_first} + {1'b0, count_second};
    den   = (total > pvtg_pkg::DVSR_W'(2)) ? total - pvtg_pkg::DVSR_W'(2)
                                           : pvtg_pkg::DVSR_W'(1);
    case (cmd.op)
      pvtg_pkg::DP_MUL_LO: begin
        mul_a = pvtg_pkg::MUL_W'(n_sel);
        mul_b = pvtg_pkg::MUL_W'(q_sel[pvtg_pkg::QLO_W-1:0]);
      end
      pvtg_pkg::DP_MUL_HI: begin
        mul_a = pvtg_pkg::MUL_W'(n_sel);
        mul_b = pvtg_pkg::MUL_W'(q_sel[pvtg_pkg::SUMSQ_W-1:pvtg_pkg::QLO_W]);
      end
      pvtg_pkg::DP_MUL_SQ: begin
        mul_a = s_mag;
        mul_b = s_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = pvtg_pkg::PROD_W'(mul_a) * pvtg_pkg::PROD_W'(mul_b);

    div_start    = (cmd.op == pvtg_pkg::DP_DIV_GROUP) || (cmd.op == pvtg_pkg::DP_DIV_POOL);
    div_dividend = (cmd.op == pvtg_pkg::DP_DIV_GROUP) ? {diff, pvtg_pkg::FRAC_BITS'(0)}
                                                      : pvtg_pkg::DIV_W'(ss_acc);
    div_divisor  = (cmd.op == pvtg_pkg::DP_DIV_GROUP) ? {1'b0, n_sel} : den;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pvtg_pkg::DP_MUL_LO: begin
        prod <= mul_p;
      end
      pvtg_pkg::DP_MUL_HI: begin
        prod <= mul_p;
        nq   <= prod;
      end
      pvtg_pkg::DP_MUL_SQ: begin
        prod <= mul_p;
        nq   <= nq + {prod[pvtg_pkg::PROD_W-pvtg_pkg::QLO_W-1:0], pvtg_pkg::QLO_W'(0)};
      end
      pvtg_pkg::DP_DIFF: begin
        diff <= (nq >= prod) ? nq - prod : '0;
      end
      pvtg_pkg::DP_ADD_SS: begin
        ss_acc <= cmd.grp ? ss_acc + div_quotient[pvtg_pkg::PROD_W-1:0]
                          : div_quotient[pvtg_pkg::PROD_W-1:0];
      end
      pvtg_pkg::DP_LOAD_EMPTY: begin
        pooled_variance <= '0;
        status          <= pvtg_pkg::STATUS_EMPTY;
      end
      pvtg_pkg::DP_LOAD_RESULT: begin
        pooled_variance <= (|div_quotient[pvtg_pkg::DIV_W-1:pvtg_pkg::OUT_W]) ? '1
                           : div_quotient[pvtg_pkg::OUT_W-1:0];
        status          <= overflow_seen ? pvtg_pkg::STATUS_DROPPED : pvtg_pkg::STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  pvtg_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  assign stat.group_empty = (count_first == '0) || (count_second == '0);
  assign stat.div_done    = div_done;

endmodule

// ===== rtl/pvtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// pvtg_ctrl
// Sequencer: accepts samples, then steps the datapath through the group
// terms, the pooled division and the result load.
// ----------------------------------------------------------------------------
module pvtg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pvtg_pkg::dp_stat_t stat,
  output pvtg_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_SQ,
    S_DIFF,
    S_DIV_GROUP,
    S_WAIT_GROUP,
    S_DIV_POOL,
    S_WAIT_POOL,
    S_DONE
  } state_t;

  state_t state;
  logic   grp;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      grp       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_last) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          grp   <= 1'b0;
          state <= stat.group_empty ? S_DONE : S_MUL_LO;
        end
        S_MUL_LO:    state <= S_MUL_HI;
        S_MUL_HI:    state <= S_MUL_SQ;
        S_MUL_SQ:    state <= S_DIFF;
        S_DIFF:      state <= S_DIV_GROUP;
        S_DIV_GROUP: state <= S_WAIT_GROUP;
        S_WAIT_GROUP: begin
          if (stat.div_done) begin
            if (grp) begin
              state <= S_DIV_POOL;
            end else begin
              grp   <= 1'b1;
              state <= S_MUL_LO;
            end
          end
        end
        S_DIV_POOL: state <= S_WAIT_POOL;
        S_WAIT_POOL: begin
          if (stat.div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.grp = grp;
    case (state)
      S_MUL_LO:     cmd.op = pvtg_pkg::DP_MUL_LO;
      S_MUL_HI:     cmd.op = pvtg_pkg::DP_MUL_HI;
      S_MUL_SQ:     cmd.op = pvtg_pkg::DP_MUL_SQ;
      S_DIFF:       cmd.op = pvtg_pkg::DP_DIFF;
      S_DIV_GROUP:  cmd.op = pvtg_pkg::DP_DIV_GROUP;
      S_WAIT_GROUP: cmd.op = stat.div_done ? pvtg_pkg::DP_ADD_SS : pvtg_pkg::DP_NOP;
      S_DIV_POOL:   cmd.op = pvtg_pkg::DP_DIV_POOL;
      S_DONE: begin
        if (!out_free) begin
          cmd.op = pvtg_pkg::DP_NOP;
        end else if (stat.group_empty) begin
          cmd.op = pvtg_pkg::DP_LOAD_EMPTY;
        end else begin
          cmd.op = pvtg_pkg::DP_LOAD_RESULT;
        end
      end
      default:      cmd.op = pvtg_pkg::DP_NOP;
    endcase
  end

endmodule

// ===== rtl/pooled_variance_two_group.sv =====
// ----------------------------------------------------------------------------
// pooled_variance_two_group
// Pooled variance of two sample groups, one result per data set.
// ----------------------------------------------------------------------------
// The samples channel takes one tagged sample per request. Samples flagged
// missing are skipped; a sample whose group already holds 65535 samples is
// dropped and reported in the status. While the block is idle, every
// request that is not marked last is accepted, back to back.
// The request marked last is accumulated like any other and then starts the
// evaluation, during which ready stays low. Each group term takes multiply
// steps for the low half, the high half and the square, one subtract and a
// division in the shared one-bit-per-cycle divider, as does the pooled one.
// The result is loaded after the pooled division, or with no division when
// a group is empty. The next sample is taken in the cycle after the load.
// The result waits in its output register while the receiver stalls; new
// samples are still accepted, and a following evaluation holds at its end
// until the register is free. Loading the result clears the accumulators.
// Reset empties the accumulators and drops any pending result.
// ----------------------------------------------------------------------------
module pooled_variance_two_group (
  input  logic        clk,
  input  logic        rst,
  pvtg_in_if.sink     samples,
  pvtg_out_if.source  results
);

  pvtg_pkg::dp_cmd_t  cmd;
  pvtg_pkg::dp_stat_t stat;
  logic               in_accept;

  assign in_accept = samples.valid && samples.ready;

  pvtg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_last   (samples.last),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pvtg_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .acc_en          (in_accept),
    .sample          (samples.sample),
    .group           (samples.group),
    .missing         (samples.missing),
    .cmd             (cmd),
    .stat            (stat),
    .pooled_variance (results.pooled_variance),
    .status          (results.status)
  );

endmodule

// ===== rtl/pvtg_checker.sv =====
// ----------------------------------------------------------------------------
// pvtg_checker
// Port-level checks of the pooled variance block, bound to the top level.
// ----------------------------------------------------------------------------
module pvtg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pvtg_pkg::OUT_W-1:0] pooled_variance,
  input logic [1:0]                 status
);

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_last_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input ready right after the last request");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pooled_variance) && $stable(status))
    else $error("stalled result changed");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == pvtg_pkg::STATUS_EMPTY |-> pooled_variance == '0)
    else $error("empty group result is not zero");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == pvtg_pkg::STATUS_OK || status == pvtg_pkg::STATUS_EMPTY ||
                  status == pvtg_pkg::STATUS_DROPPED)
    else $error("undefined status code");

endmodule

bind pooled_variance_two_group pvtg_checker u_pvtg_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (samples.valid),
  .in_ready        (samples.ready),
  .in_last         (samples.last),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .pooled_variance (results.pooled_variance),
  .status          (results.status)
);
